/* hw/rtl/irt_pkg.sv */
`default_nettype none
package irt_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int INODE_BITS = 16;
   localparam int COUNT_BITS = 8;
   localparam int MAX_RESULTS = 64;

   localparam int FUNC_BITS = 2;
   localparam int SLOT_FIELD_BITS = 6;
   localparam int IDX_BITS = $clog2(TABLE_SLOTS);
   localparam int SCAN_BITS = $clog2(TABLE_SLOTS + 1);
   localparam int EMIT_BITS = $clog2(MAX_RESULTS);

   localparam int REQ_DATA_BITS = ((INODE_BITS + SLOT_FIELD_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SLOT_FIELD_BITS + INODE_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 7;

   localparam logic [FUNC_BITS-1:0] FUNC_GET = FUNC_BITS'(0);
   localparam logic [FUNC_BITS-1:0] FUNC_PUT = FUNC_BITS'(1);
   localparam logic [FUNC_BITS-1:0] FUNC_FLUSH = FUNC_BITS'(2);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef struct packed {
      logic [FUNC_BITS-1:0]       func;
      logic [INODE_BITS-1:0]      inode_number;
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic                       unlinked;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_BITS-1:0] out_slot;
      logic [INODE_BITS-1:0]      out_inode;
      logic                       hit;
      logic                       fill;
      logic                       full_res;
      logic                       write_back;
      logic                       free_inode;
      logic                       error;
      logic                       none_in_use;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [INODE_BITS-1:0] inode;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] waddr;
      entry_type           wdata;
      logic                re;
      logic [IDX_BITS-1:0] raddr;
   } ram_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GET_SCAN,
      ST_GET_HIT,
      ST_GET_MISS,
      ST_PUT_RD,
      ST_PUT_WR,
      ST_FL_SCAN,
      ST_FL_RD,
      ST_BAD
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/irt_ram.sv */
`default_nettype none
module irt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* hw/rtl/irt_out_stage.sv */
`default_nettype none
module irt_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire irt_pkg::rsp_type load_data,
   output      logic             load_ready,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      irt_pkg::rsp_type rsp_data
);
   import irt_pkg::*;

   logic    vld_ff;
   logic    vld_in;
   rsp_type data_ff;

   // The register can take a new beat when it is empty or when the one it holds leaves this cycle.
   assign load_ready = !vld_ff || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_data = data_ff;

endmodule
`default_nettype wire

/* hw/rtl/irt_ctrl.sv */
`default_nettype none
module irt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire irt_pkg::req_type     req_data,
   input  wire logic                 out_ready,
   output      logic                 out_load,
   output      irt_pkg::rsp_type     out_data,
   output      irt_pkg::ram_req_type ram_req,
   input  wire irt_pkg::entry_type   rd_data
);
   import irt_pkg::*;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [SCAN_BITS-1:0]   idx_ff, idx_in;
   logic [IDX_BITS-1:0]    sel_idx_ff, sel_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   free_vld_ff, free_vld_in;
   logic [IDX_BITS-1:0]    free_idx_ff, free_idx_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [EMIT_BITS-1:0]   emit_ff, emit_in;

   logic                   scan_end;
   logic [IDX_BITS-1:0]    scan_idx;
   logic [IDX_BITS-1:0]    put_idx;
   logic                   put_ok;
   logic                   hit_now;

   assign scan_end = (idx_ff == SCAN_BITS'(TABLE_SLOTS));
   assign scan_idx = idx_ff[IDX_BITS-1:0];
   assign put_idx = IDX_BITS'(req_ff.slot);
   assign put_ok = (32'(req_ff.slot) < TABLE_SLOTS) && used_ff[put_idx];
   // The slot read last cycle is compared now; only an in-use slot can match.
   assign hit_now = cmp_vld_ff && used_ff[sel_idx_ff]
                    && (rd_data.inode == req_ff.inode_number);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      sel_idx_in = sel_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      pend_vld_in = pend_vld_ff;
      emit_in = emit_ff;
      req_ready = 1'b0;
      out_load = 1'b0;
      out_data = '0;
      ram_req = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_in = '0;
            cmp_vld_in = 1'b0;
            free_vld_in = 1'b0;
            pend_vld_in = 1'b0;
            emit_in = '0;
            if (req_valid) begin
               req_in = req_data;
               case (req_data.func)
                  FUNC_GET:   state_in = ST_GET_SCAN;
                  FUNC_PUT:   state_in = ST_PUT_RD;
                  FUNC_FLUSH: state_in = ST_FL_SCAN;
                  default:    state_in = ST_BAD;
               endcase
            end
         end

         ST_GET_SCAN: begin
            if (hit_now) begin
               // Read port stays idle so the matching entry holds for the update.
               state_in = ST_GET_HIT;
            end else if (!scan_end) begin
               ram_req.re = 1'b1;
               ram_req.raddr = scan_idx;
               sel_idx_in = scan_idx;
               cmp_vld_in = 1'b1;
               idx_in = idx_ff + SCAN_BITS'(1);
               if (!used_ff[scan_idx] && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = scan_idx;
               end
            end else begin
               cmp_vld_in = 1'b0;
               if (!cmp_vld_ff) begin
                  state_in = ST_GET_MISS;
               end
            end
         end

         ST_GET_HIT: begin
            out_data.out_slot = SLOT_FIELD_BITS'(sel_idx_ff);
            out_data.out_inode = req_ff.inode_number;
            out_data.hit = 1'b1;
            out_data.error = (rd_data.count == COUNT_MAX);
            out_data.last = 1'b1;
            if (out_ready) begin
               out_load = 1'b1;
               if (rd_data.count != COUNT_MAX) begin
                  ram_req.we = 1'b1;
                  ram_req.waddr = sel_idx_ff;
                  ram_req.wdata.count = rd_data.count + COUNT_ONE;
                  ram_req.wdata.inode = rd_data.inode;
               end
               state_in = ST_IDLE;
            end
         end

         ST_GET_MISS: begin
            out_data.out_inode = req_ff.inode_number;
            out_data.last = 1'b1;
            if (free_vld_ff) begin
               out_data.out_slot = SLOT_FIELD_BITS'(free_idx_ff);
               out_data.fill = 1'b1;
            end else begin
               out_data.full_res = 1'b1;
            end
            if (out_ready) begin
               out_load = 1'b1;
               if (free_vld_ff) begin
                  ram_req.we = 1'b1;
                  ram_req.waddr = free_idx_ff;
                  ram_req.wdata.count = COUNT_ONE;
                  ram_req.wdata.inode = req_ff.inode_number;
                  used_in[free_idx_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         ST_PUT_RD: begin
            if (!put_ok) begin
               out_data.out_slot = req_ff.slot;
               out_data.error = 1'b1;
               out_data.last = 1'b1;
               if (out_ready) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               ram_req.re = 1'b1;
               ram_req.raddr = put_idx;
               state_in = ST_PUT_WR;
            end
         end

         ST_PUT_WR: begin
            out_data.out_slot = req_ff.slot;
            out_data.out_inode = rd_data.inode;
            out_data.last = 1'b1;
            if (rd_data.count == COUNT_ONE) begin
               out_data.write_back = 1'b1;
               out_data.free_inode = req_ff.unlinked;
            end
            if (out_ready) begin
               out_load = 1'b1;
               if (rd_data.count == COUNT_ONE) begin
                  used_in[put_idx] = 1'b0;
               end else begin
                  ram_req.we = 1'b1;
                  ram_req.waddr = put_idx;
                  ram_req.wdata.count = rd_data.count - COUNT_ONE;
                  ram_req.wdata.inode = rd_data.inode;
               end
               state_in = ST_IDLE;
            end
         end

         ST_FL_SCAN: begin
            // A pending slot is sent only once the next in-use slot is found, the scan ends or the
            // result limit is reached, so the final one can carry last.
            out_data.out_slot = SLOT_FIELD_BITS'(sel_idx_ff);
            out_data.out_inode = rd_data.inode;
            out_data.write_back = 1'b1;
            if (pend_vld_ff && (scan_end || emit_ff == EMIT_BITS'(MAX_RESULTS - 1))) begin
               out_data.last = 1'b1;
               if (out_ready) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (scan_end) begin
               out_data = '0;
               out_data.none_in_use = 1'b1;
               out_data.last = 1'b1;
               if (out_ready) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (used_ff[scan_idx]) begin
               if (!pend_vld_ff || out_ready) begin
                  if (pend_vld_ff) begin
                     out_load = 1'b1;
                     emit_in = emit_ff + EMIT_BITS'(1);
                  end
                  pend_vld_in = 1'b0;
                  ram_req.re = 1'b1;
                  ram_req.raddr = scan_idx;
                  sel_idx_in = scan_idx;
                  idx_in = idx_ff + SCAN_BITS'(1);
                  state_in = ST_FL_RD;
               end
            end else begin
               idx_in = idx_ff + SCAN_BITS'(1);
            end
         end

         ST_FL_RD: begin
            pend_vld_in = 1'b1;
            state_in = ST_FL_SCAN;
         end

         ST_BAD: begin
            out_data.error = 1'b1;
            out_data.last = 1'b1;
            if (out_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         idx_ff <= '0;
         cmp_vld_ff <= 1'b0;
         free_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         emit_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         idx_ff <= idx_in;
         cmp_vld_ff <= cmp_vld_in;
         free_vld_ff <= free_vld_in;
         pend_vld_ff <= pend_vld_in;
         emit_ff <= emit_in;
      end
      req_ff <= req_in;
      sel_idx_ff <= sel_idx_in;
      free_idx_ff <= free_idx_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/refcounted_inode_table.sv */
`default_nettype none
// Reference-counted inode slot table. Each slot's count and inode number live in one
// single-port-read RAM, and a bank of in-use flags (cleared at reset) marks slots whose
// count is not zero, so no clearing pass is needed. One request is handled at a time;
// a new one is taken in the idle cycle after the previous one has placed its last beat
// in the output register. A get scans the slots through the RAM read port, one per cycle,
// and stops early on a hit. A put reads the slot, then does the modify and write-back
// together; a put to a slot that is out of range or not in use gets an error beat and no
// read. A flush steps through the slots in order, giving each in-use slot its own RAM read.
// Flush reports at most 64 slots, lowest first, with tlast on the final one. Output
// stalls hold the sequencer in place.
module refcounted_inode_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // inode_number, slot, unlinked, zero pad
   input  wire logic [irt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // func
   input  wire logic [irt_pkg::FUNC_BITS-1:0]       req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // out_slot, out_inode, zero pad
   output      logic [irt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // hit, fill, full_res, write_back, free_inode, error, none_in_use
   output      logic [irt_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   output      logic                                rsp_tlast
);
   import irt_pkg::*;

   req_type     req_fields;
   rsp_type     load_data;
   rsp_type     rsp_data;
   logic        out_ready;
   logic        out_load;
   ram_req_type ram_req;
   entry_type   rd_data;

   assign req_fields.func = req_tuser;
   assign req_fields.inode_number = req_tdata[INODE_BITS-1:0];
   assign req_fields.slot = req_tdata[INODE_BITS +: SLOT_FIELD_BITS];
   assign req_fields.unlinked = req_tdata[INODE_BITS + SLOT_FIELD_BITS];

   irt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (rd_data)
   );

   irt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_data  (req_fields),
      .out_ready (out_ready),
      .out_load  (out_load),
      .out_data  (load_data),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   irt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_data  (load_data),
      .load_ready (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_data.out_inode, rsp_data.out_slot});
   assign rsp_tuser = {rsp_data.none_in_use, rsp_data.error, rsp_data.free_inode,
                       rsp_data.write_back, rsp_data.full_res, rsp_data.fill,
                       rsp_data.hit};
   assign rsp_tlast = rsp_data.last;

endmodule
`default_nettype wire
